FILE: rtl/core/selective_repeat_sender_window_defines.svh
// Assertion macros shared by the sender window checkers.
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_DEFINES_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SRSW_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SRSW_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/srsw_pkg.sv
// Types and codes for the selective-repeat sender window.
package srsw_pkg;

    typedef enum logic [1:0] {
        ACT_SEND    = 2'd0,
        ACT_ACK     = 2'd1,
        ACT_TIMEOUT = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_SLIDE = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

endpackage

FILE: rtl/core/srsw_cmd_if.sv
// Command channel: send, acknowledgement and timeout events.
interface srsw_cmd_if #(
    parameter int SEQ_BITS     = 3,
    parameter int PAYLOAD_BITS = 64
);
    logic                    valid;
    logic                    ready;
    logic [1:0]              action;
    logic [SEQ_BITS-1:0]     seq_num;
    logic                    ack_ok;
    logic [PAYLOAD_BITS-1:0] payload;

    modport source (output valid, action, seq_num, ack_ok, payload, input ready);
    modport sink   (input valid, action, seq_num, ack_ok, payload, output ready);
endinterface

FILE: rtl/core/srsw_rsp_if.sv
// Response channel: packet, timer commands and window status.
interface srsw_rsp_if #(
    parameter int SEQ_BITS     = 3,
    parameter int PAYLOAD_BITS = 64,
    parameter int CNT_BITS     = 3
);
    logic                    valid;
    logic                    ready;
    logic                    accepted;
    logic                    emit_packet;
    logic [SEQ_BITS-1:0]     out_seq;
    logic [PAYLOAD_BITS-1:0] out_payload;
    logic                    start_timer;
    logic                    stop_timer;
    logic [SEQ_BITS-1:0]     timer_seq;
    logic                    window_full;
    logic [SEQ_BITS-1:0]     window_base;
    logic [CNT_BITS-1:0]     outstanding;

    modport source (output valid, accepted, emit_packet, out_seq, out_payload,
                    start_timer, stop_timer, timer_seq, window_full, window_base,
                    outstanding, input ready);
    modport sink   (input valid, accepted, emit_packet, out_seq, out_payload,
                    start_timer, stop_timer, timer_seq, window_full, window_base,
                    outstanding, output ready);
endinterface

FILE: rtl/core/srsw_ram.sv
// Single-port RAM with registered read data.
module srsw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: rtl/core/selective_repeat_sender_window.sv
// Selective-repeat ARQ sender window: window pointers, ack marks and packet store.
//
// cmd carries one event per transaction: send (store payload, emit it, start its
// timer), acknowledgement (checksum verdict in ack_ok; stops the timer and marks
// the slot, the base slides when the base is acknowledged) or timeout (resend the
// stored packet and restart its timer). Every command yields exactly one rsp
// transaction with the timer commands and the window status after the event.
// One command is worked on at a time; cmd.ready is high only when the
// sequencer is idle. A send, a plain ack or an ignored event goes straight
// to the done state; a timeout first passes the read state (packet RAM read),
// and an ack that slides the base passes the slide state, which tests one ack
// flag per cycle. From the done state the result is loaded into the rsp
// register once that register is free. A new command is taken the cycle after
// the rsp register is loaded, so none is taken while another is in work.
// While rsp.ready is low the finished result holds in the rsp register; the
// next command is still taken and worked on, and its result waits in the
// sequencer until the register frees.
// Reset clears the pointers, the outstanding count and all ack flags; the packet
// store is not cleared and holds what later sends write.
module selective_repeat_sender_window #(
    parameter int SEQ_SPACE    = 8,
    parameter int WINDOW       = 4,
    parameter int PAYLOAD_BITS = 64
) (
    input logic       clk,
    input logic       rst_n,
    srsw_cmd_if.sink  cmd,
    srsw_rsp_if.source rsp
);

    localparam int SEQ_BITS = $clog2(SEQ_SPACE);
    localparam int CNT_BITS = $clog2(WINDOW + 1);
    localparam int CMP_BITS = (SEQ_BITS > CNT_BITS) ? SEQ_BITS : CNT_BITS;
    localparam logic [SEQ_BITS:0]   SPACE_W  = (SEQ_BITS + 1)'(SEQ_SPACE);
    localparam logic [SEQ_BITS-1:0] SEQ_LAST = SEQ_BITS'(SEQ_SPACE - 1);
    localparam logic [CNT_BITS-1:0] WIN_W    = CNT_BITS'(WINDOW);

    function automatic logic [SEQ_BITS-1:0] wrap_inc(input logic [SEQ_BITS-1:0] v);
        return (v == SEQ_LAST) ? '0 : v + 1'b1;
    endfunction

    srsw_pkg::state_t state_reg, state_next;
    logic [SEQ_BITS-1:0]  base_reg, base_next;
    logic [SEQ_BITS-1:0]  next_ptr_reg, next_ptr_next;
    logic [CNT_BITS-1:0]  flight_reg, flight_next;
    logic [SEQ_SPACE-1:0] acked_reg, acked_next;

    // pending result of the command in work
    logic                    res_acc_reg, res_acc_next;
    logic                    res_emit_reg, res_emit_next;
    logic [SEQ_BITS-1:0]     res_oseq_reg, res_oseq_next;
    logic [PAYLOAD_BITS-1:0] res_pay_reg, res_pay_next;
    logic                    res_start_reg, res_start_next;
    logic                    res_stop_reg, res_stop_next;
    logic [SEQ_BITS-1:0]     res_tseq_reg, res_tseq_next;

    // rsp output register
    logic                    out_valid_reg, out_valid_next;
    logic                    out_acc_reg, out_emit_reg, out_start_reg, out_stop_reg;
    logic [SEQ_BITS-1:0]     out_oseq_reg, out_tseq_reg, out_base_reg;
    logic [PAYLOAD_BITS-1:0] out_pay_reg;
    logic                    out_full_reg;
    logic [CNT_BITS-1:0]     out_flight_reg;

    srsw_pkg::action_t   act;
    logic [SEQ_BITS-1:0] seq;
    logic [SEQ_BITS:0]   seq_ext;
    logic [SEQ_BITS:0]   off_ext;
    logic                in_win;
    logic                take;
    logic                load;
    logic                ram_we;
    logic [SEQ_BITS-1:0] ram_addr;
    logic [PAYLOAD_BITS-1:0] ram_rdata;

    assign act     = srsw_pkg::action_t'(cmd.action);
    assign seq_ext = {1'b0, cmd.seq_num};
    // reduce modulo the sequence space: the port value stays below twice its size
    assign seq     = (seq_ext >= SPACE_W) ? SEQ_BITS'(seq_ext - SPACE_W) : cmd.seq_num;
    assign off_ext = (seq >= base_reg) ? {1'b0, seq} - {1'b0, base_reg}
                                       : {1'b0, seq} + SPACE_W - {1'b0, base_reg};
    assign in_win  = CMP_BITS'(SEQ_BITS'(off_ext)) < CMP_BITS'(flight_reg);

    assign take      = (state_reg == srsw_pkg::S_IDLE) && cmd.valid;
    assign load      = (state_reg == srsw_pkg::S_DONE) && (!out_valid_reg || rsp.ready);
    assign cmd.ready = (state_reg == srsw_pkg::S_IDLE);
    assign ram_addr  = (act == srsw_pkg::ACT_SEND) ? next_ptr_reg : seq;
    assign ram_we    = take && (act == srsw_pkg::ACT_SEND) && (flight_reg < WIN_W);

    srsw_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (SEQ_SPACE)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (cmd.payload),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        next_ptr_next  = next_ptr_reg;
        flight_next    = flight_reg;
        acked_next     = acked_reg;
        res_acc_next   = res_acc_reg;
        res_emit_next  = res_emit_reg;
        res_oseq_next  = res_oseq_reg;
        res_pay_next   = res_pay_reg;
        res_start_next = res_start_reg;
        res_stop_next  = res_stop_reg;
        res_tseq_next  = res_tseq_reg;

        unique case (state_reg)
            srsw_pkg::S_IDLE:
            begin
                if (cmd.valid)
                begin
                    res_acc_next   = 1'b0;
                    res_emit_next  = 1'b0;
                    res_oseq_next  = '0;
                    res_pay_next   = '0;
                    res_start_next = 1'b0;
                    res_stop_next  = 1'b0;
                    res_tseq_next  = '0;
                    state_next     = srsw_pkg::S_DONE;
                    unique case (act)
                        srsw_pkg::ACT_SEND:
                        begin
                            if (flight_reg < WIN_W)
                            begin
                                acked_next[next_ptr_reg] = 1'b0;
                                res_acc_next   = 1'b1;
                                res_emit_next  = 1'b1;
                                res_oseq_next  = next_ptr_reg;
                                res_pay_next   = cmd.payload;
                                res_start_next = 1'b1;
                                res_tseq_next  = next_ptr_reg;
                                next_ptr_next  = wrap_inc(next_ptr_reg);
                                flight_next    = flight_reg + 1'b1;
                            end
                        end
                        srsw_pkg::ACT_ACK:
                        begin
                            if (cmd.ack_ok && in_win)
                            begin
                                acked_next[seq] = 1'b1;
                                res_acc_next    = 1'b1;
                                res_stop_next   = 1'b1;
                                res_tseq_next   = seq;
                                if (seq == base_reg)
                                begin
                                    state_next = srsw_pkg::S_SLIDE;
                                end
                            end
                        end
                        srsw_pkg::ACT_TIMEOUT:
                        begin
                            res_acc_next   = 1'b1;
                            res_emit_next  = 1'b1;
                            res_oseq_next  = seq;
                            res_start_next = 1'b1;
                            res_tseq_next  = seq;
                            state_next     = srsw_pkg::S_READ;
                        end
                        srsw_pkg::ACT_NONE:
                        begin
                            state_next = srsw_pkg::S_DONE;
                        end
                    endcase
                end
            end
            srsw_pkg::S_READ:
            begin
                res_pay_next = ram_rdata;
                state_next   = srsw_pkg::S_DONE;
            end
            srsw_pkg::S_SLIDE:
            begin
                // advance over one marked slot per cycle
                if ((flight_reg != '0) && acked_reg[base_reg])
                begin
                    acked_next[base_reg] = 1'b0;
                    base_next            = wrap_inc(base_reg);
                    flight_next          = flight_reg - 1'b1;
                end
                else
                begin
                    state_next = srsw_pkg::S_DONE;
                end
            end
            srsw_pkg::S_DONE:
            begin
                if (load)
                begin
                    state_next = srsw_pkg::S_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srsw_pkg::S_IDLE;
            base_reg      <= '0;
            next_ptr_reg  <= '0;
            flight_reg    <= '0;
            acked_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            next_ptr_reg  <= next_ptr_next;
            flight_reg    <= flight_next;
            acked_reg     <= acked_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_acc_reg   <= res_acc_next;
        res_emit_reg  <= res_emit_next;
        res_oseq_reg  <= res_oseq_next;
        res_pay_reg   <= res_pay_next;
        res_start_reg <= res_start_next;
        res_stop_reg  <= res_stop_next;
        res_tseq_reg  <= res_tseq_next;
        if (load)
        begin
            out_acc_reg    <= res_acc_reg;
            out_emit_reg   <= res_emit_reg;
            out_oseq_reg   <= res_oseq_reg;
            out_pay_reg    <= res_pay_reg;
            out_start_reg  <= res_start_reg;
            out_stop_reg   <= res_stop_reg;
            out_tseq_reg   <= res_tseq_reg;
            out_full_reg   <= (flight_reg == WIN_W);
            out_base_reg   <= base_reg;
            out_flight_reg <= flight_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.accepted    = out_acc_reg;
    assign rsp.emit_packet = out_emit_reg;
    assign rsp.out_seq     = out_oseq_reg;
    assign rsp.out_payload = out_pay_reg;
    assign rsp.start_timer = out_start_reg;
    assign rsp.stop_timer  = out_stop_reg;
    assign rsp.timer_seq   = out_tseq_reg;
    assign rsp.window_full = out_full_reg;
    assign rsp.window_base = out_base_reg;
    assign rsp.outstanding = out_flight_reg;

endmodule

FILE: rtl/core/srsw_checker.sv
// Port-level checker for the sender window, bound to the top level.
`include "selective_repeat_sender_window_defines.svh"

module srsw_checker #(
    parameter int SEQ_SPACE    = 8,
    parameter int WINDOW       = 4,
    parameter int PAYLOAD_BITS = 64
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic                          rsp_accepted,
    input logic                          rsp_emit,
    input logic [$clog2(SEQ_SPACE)-1:0]  rsp_out_seq,
    input logic [PAYLOAD_BITS-1:0]       rsp_out_payload,
    input logic                          rsp_start,
    input logic                          rsp_stop,
    input logic [$clog2(SEQ_SPACE)-1:0]  rsp_timer_seq,
    input logic                          rsp_full,
    input logic [$clog2(WINDOW+1)-1:0]   rsp_outstanding
);

    localparam int CNT_BITS = $clog2(WINDOW + 1);
    localparam logic [CNT_BITS-1:0] WIN_W = CNT_BITS'(WINDOW);

    // one command in work at a time
    `SRSW_ASSERT_NEXT(a_cmd_single, cmd_valid && cmd_ready, !cmd_ready, "command taken while busy")
    `SRSW_ASSERT_IMPL(a_emit_timer, rsp_valid && rsp_emit,
        rsp_accepted && rsp_start && !rsp_stop && (rsp_timer_seq == rsp_out_seq),
        "emitted packet without matching timer start")
    `SRSW_ASSERT_IMPL(a_refused_quiet, rsp_valid && !rsp_accepted,
        !rsp_emit && !rsp_start && !rsp_stop && (rsp_out_payload == '0),
        "refused event issued a command")
    `SRSW_ASSERT_IMPL(a_full_flag, rsp_valid, rsp_full == (rsp_outstanding == WIN_W),
        "window_full disagrees with outstanding")
    `SRSW_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_payload),
        "stalled response changed")

endmodule

bind selective_repeat_sender_window srsw_checker #(
    .SEQ_SPACE    (SEQ_SPACE),
    .WINDOW       (WINDOW),
    .PAYLOAD_BITS (PAYLOAD_BITS)
) u_srsw_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_accepted    (rsp.accepted),
    .rsp_emit        (rsp.emit_packet),
    .rsp_out_seq     (rsp.out_seq),
    .rsp_out_payload (rsp.out_payload),
    .rsp_start       (rsp.start_timer),
    .rsp_stop        (rsp.stop_timer),
    .rsp_timer_seq   (rsp.timer_seq),
    .rsp_full        (rsp.window_full),
    .rsp_outstanding (rsp.outstanding)
);

FILE: sim/selective_repeat_sender_window_tb.sv
// Self-checking testbench for the selective-repeat sender window.
module selective_repeat_sender_window_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEQ_SPACE    = 8;
    localparam int WINDOW       = 4;
    localparam int PAYLOAD_BITS = 64;
    localparam int SEQ_BITS     = 3;
    localparam int CNT_BITS     = 3;
    localparam int CLK_PERIOD   = 10;
    localparam int RANDOM_ITEMS = 1500;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int TIMEOUT_NS   = 2_000_000;

    typedef struct {
        srsw_pkg::action_t       action;
        logic [SEQ_BITS-1:0]     seq;
        logic                    ack_ok;
        logic [PAYLOAD_BITS-1:0] payload;
    } cmd_item_t;

    typedef struct {
        logic                    accepted;
        logic                    emit;
        logic [SEQ_BITS-1:0]     oseq;
        logic [PAYLOAD_BITS-1:0] opay;
        logic                    start;
        logic                    stop;
        logic [SEQ_BITS-1:0]     tseq;
        logic                    full;
        logic [SEQ_BITS-1:0]     base;
        logic [CNT_BITS-1:0]     count;
    } window_rsp_t;

    class window_scoreboard;
        // sequence numbers are 3 bits wide, so plain arithmetic wraps modulo SEQ_SPACE
        bit [SEQ_BITS-1:0]       base_seq;
        bit [SEQ_BITS-1:0]       next_seq;
        int                      in_flight;
        bit                      acked [SEQ_SPACE];
        bit                      written [SEQ_SPACE];
        logic [PAYLOAD_BITS-1:0] packet_copy [SEQ_SPACE];
        window_rsp_t             expected_rsp [$];
        int errors, checked;
        int n_send, n_refused, n_ack, n_slide, n_timeout, n_ignored;

        function void report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endfunction

        function bit in_window(bit [SEQ_BITS-1:0] s);
            bit [SEQ_BITS-1:0] off;
            off = s - base_seq;
            return off < in_flight;
        endfunction

        function window_rsp_t predict_response(cmd_item_t c);
            window_rsp_t r;
            bit [SEQ_BITS-1:0] old_base;
            r = '{default: '0};
            old_base = base_seq;
            case (c.action)
                srsw_pkg::ACT_SEND:
                    if (in_flight < WINDOW) begin
                        packet_copy[next_seq] = c.payload;
                        written[next_seq] = 1'b1;
                        acked[next_seq] = 1'b0;
                        r.accepted = 1'b1;
                        r.emit = 1'b1;
                        r.oseq = next_seq;
                        r.opay = c.payload;
                        r.start = 1'b1;
                        r.tseq = next_seq;
                        next_seq++;
                        in_flight++;
                        n_send++;
                    end else begin
                        n_refused++;
                    end
                srsw_pkg::ACT_ACK:
                    if (c.ack_ok && in_window(c.seq)) begin
                        r.accepted = 1'b1;
                        r.stop = 1'b1;
                        r.tseq = c.seq;
                        acked[c.seq] = 1'b1;
                        n_ack++;
                        if (c.seq == base_seq) begin
                            // slide over every marked slot, clearing the marks
                            while (in_flight > 0 && acked[base_seq]) begin
                                acked[base_seq] = 1'b0;
                                base_seq++;
                                in_flight--;
                            end
                        end
                        if (base_seq != old_base)
                            n_slide++;
                    end else begin
                        n_ignored++;
                    end
                srsw_pkg::ACT_TIMEOUT: begin
                    r.accepted = 1'b1;
                    r.emit = 1'b1;
                    r.oseq = c.seq;
                    r.opay = packet_copy[c.seq];
                    r.start = 1'b1;
                    r.tseq = c.seq;
                    n_timeout++;
                end
                default:
                    n_ignored++;
            endcase
            r.full = (in_flight == WINDOW);
            r.base = base_seq;
            r.count = CNT_BITS'(in_flight);
            return r;
        endfunction

        function window_rsp_t note_command(cmd_item_t c);
            window_rsp_t r;
            r = predict_response(c);
            expected_rsp.push_back(r);
            return r;
        endfunction

        function void check_response(window_rsp_t got);
            window_rsp_t w;
            if (expected_rsp.size() == 0) begin
                report("response transaction with nothing expected");
                return;
            end
            w = expected_rsp.pop_front();
            checked++;
            if (got.accepted !== w.accepted)
                report($sformatf("rsp %0d accepted: got %b want %b", checked, got.accepted,
                                 w.accepted));
            if (got.emit !== w.emit)
                report($sformatf("rsp %0d emit_packet: got %b want %b", checked, got.emit,
                                 w.emit));
            if (got.oseq !== w.oseq)
                report($sformatf("rsp %0d out_seq: got %0d want %0d", checked, got.oseq,
                                 w.oseq));
            if (got.opay !== w.opay)
                report($sformatf("rsp %0d out_payload: got %h want %h", checked, got.opay,
                                 w.opay));
            if (got.start !== w.start)
                report($sformatf("rsp %0d start_timer: got %b want %b", checked, got.start,
                                 w.start));
            if (got.stop !== w.stop)
                report($sformatf("rsp %0d stop_timer: got %b want %b", checked, got.stop,
                                 w.stop));
            if (got.tseq !== w.tseq)
                report($sformatf("rsp %0d timer_seq: got %0d want %0d", checked, got.tseq,
                                 w.tseq));
            if (got.full !== w.full)
                report($sformatf("rsp %0d window_full: got %b want %b", checked, got.full,
                                 w.full));
            if (got.base !== w.base)
                report($sformatf("rsp %0d window_base: got %0d want %0d", checked, got.base,
                                 w.base));
            if (got.count !== w.count)
                report($sformatf("rsp %0d outstanding: got %0d want %0d", checked, got.count,
                                 w.count));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    srsw_cmd_if #(.SEQ_BITS(SEQ_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)) cmd ();
    srsw_rsp_if #(.SEQ_BITS(SEQ_BITS), .PAYLOAD_BITS(PAYLOAD_BITS), .CNT_BITS(CNT_BITS)) rsp ();

    selective_repeat_sender_window #(
        .SEQ_SPACE   (SEQ_SPACE),
        .WINDOW      (WINDOW),
        .PAYLOAD_BITS(PAYLOAD_BITS)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd),
        .rsp  (rsp)
    );

    window_scoreboard sb = new;
    int burst_left;
    int taken;

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic cmd_item_t mk(srsw_pkg::action_t a, int s, bit ok,
                                     logic [PAYLOAD_BITS-1:0] p);
        cmd_item_t c;
        c.action = a;
        c.seq = SEQ_BITS'(s);
        c.ack_ok = ok;
        c.payload = p;
        return c;
    endfunction

    function automatic cmd_item_t random_command();
        cmd_item_t c;
        int pick;
        int k;
        c.action = srsw_pkg::ACT_SEND;
        c.seq = SEQ_BITS'($urandom_range(0, SEQ_SPACE - 1));
        c.ack_ok = 1'($urandom_range(0, 1));
        c.payload = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 38) begin
            c.action = srsw_pkg::ACT_SEND;
        end else if (pick < 70) begin
            // ack inside the window, leaning on the base to force slides
            c.action = srsw_pkg::ACT_ACK;
            c.ack_ok = 1'b1;
            if (sb.in_flight > 0)
                c.seq = ($urandom_range(0, 2) == 0) ? sb.base_seq :
                        sb.base_seq + SEQ_BITS'($urandom_range(0, sb.in_flight - 1));
        end else if (pick < 84) begin
            c.action = srsw_pkg::ACT_TIMEOUT;
            if (sb.in_flight > 0)
                c.seq = sb.base_seq + SEQ_BITS'($urandom_range(0, sb.in_flight - 1));
        end else if (pick < 90) begin
            c.action = srsw_pkg::ACT_ACK;
            c.ack_ok = 1'b0;
        end else if (pick < 95) begin
            // stale ack outside the window
            c.action = srsw_pkg::ACT_ACK;
            c.ack_ok = 1'b1;
            c.seq = sb.base_seq + SEQ_BITS'(sb.in_flight) +
                    SEQ_BITS'($urandom_range(0, SEQ_SPACE - 1 - sb.in_flight));
        end else if (pick < 98) begin
            c.action = srsw_pkg::ACT_NONE;
        end else begin
            c.action = srsw_pkg::ACT_TIMEOUT;
        end
        // never time out a number whose store entry was never written
        if (c.action == srsw_pkg::ACT_TIMEOUT && !sb.written[c.seq]) begin
            k = 0;
            while (k < SEQ_SPACE && !sb.written[c.seq]) begin
                c.seq++;
                k++;
            end
            if (!sb.written[c.seq])
                c.action = srsw_pkg::ACT_SEND;
        end
        return c;
    endfunction

    task automatic issue_command(cmd_item_t c);
        cmd.valid   <= 1'b1;
        cmd.action  <= c.action;
        cmd.seq_num <= c.seq;
        cmd.ack_ok  <= c.ack_ok;
        cmd.payload <= c.payload;
        do
            @(posedge clk);
        while (cmd.ready !== 1'b1);
        void'(sb.note_command(c));
        taken++;
        if (burst_left == 0) begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(0, 24);
        end else begin
            burst_left--;
        end
    endtask

    // receiver: stall pattern changes per stretch, with two long hold-offs
    initial begin
        window_rsp_t got;
        int mode;
        int stretch;
        int hold;
        int tick;
        mode = 0;
        stretch = 0;
        hold = 0;
        tick = 0;
        rsp.ready <= 1'b0;
        forever begin
            @(posedge clk);
            tick++;
            if (rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
                got.accepted = rsp.accepted;
                got.emit = rsp.emit_packet;
                got.oseq = rsp.out_seq;
                got.opay = rsp.out_payload;
                got.start = rsp.start_timer;
                got.stop = rsp.stop_timer;
                got.tseq = rsp.timer_seq;
                got.full = rsp.window_full;
                got.base = rsp.window_base;
                got.count = rsp.outstanding;
                sb.check_response(got);
                if (sb.checked == 400 || sb.checked == 1100)
                    hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                rsp.ready <= 1'b0;
            end else begin
                if (stretch == 0) begin
                    mode = $urandom_range(0, 2);
                    stretch = $urandom_range(10, 60);
                end
                stretch--;
                case (mode)
                    0: rsp.ready <= 1'b1;
                    1: rsp.ready <= 1'($urandom_range(0, 1));
                    default: rsp.ready <= (tick % 4 == 0);
                endcase
            end
        end
    end

    initial begin
        cmd.valid   <= 1'b0;
        cmd.action  <= srsw_pkg::ACT_NONE;
        cmd.seq_num <= '0;
        cmd.ack_ok  <= 1'b0;
        cmd.payload <= '0;
        burst_left = 0;
        taken = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stale ack on an empty window and an unknown action
        issue_command(mk(srsw_pkg::ACT_ACK, 0, 1'b1, '0));
        issue_command(mk(srsw_pkg::ACT_NONE, 7, 1'b1, '1));
        // fill the window, then one refused send
        issue_command(mk(srsw_pkg::ACT_SEND, 5, 1'b0, '0));
        issue_command(mk(srsw_pkg::ACT_SEND, 0, 1'b1, '1));
        issue_command(mk(srsw_pkg::ACT_SEND, 0, 1'b0, 64'hAAAA_AAAA_AAAA_AAAA));
        issue_command(mk(srsw_pkg::ACT_SEND, 0, 1'b0, 64'h5555_5555_5555_5555));
        issue_command(mk(srsw_pkg::ACT_SEND, 0, 1'b0, 64'h0123_4567_89AB_CDEF));
        // bad checksum, out-of-order ack, repeated ack, resend, ack past the window
        issue_command(mk(srsw_pkg::ACT_ACK, 1, 1'b0, '0));
        issue_command(mk(srsw_pkg::ACT_ACK, 2, 1'b1, '0));
        issue_command(mk(srsw_pkg::ACT_ACK, 2, 1'b1, '0));
        issue_command(mk(srsw_pkg::ACT_TIMEOUT, 1, 1'b0, '0));
        issue_command(mk(srsw_pkg::ACT_ACK, 4, 1'b1, '0));
        issue_command(mk(srsw_pkg::ACT_ACK, 1, 1'b1, '0));
        // base ack slides over three marked slots
        issue_command(mk(srsw_pkg::ACT_ACK, 0, 1'b1, '0));
        // resend of a number no longer outstanding
        issue_command(mk(srsw_pkg::ACT_TIMEOUT, 0, 1'b1, '1));
        issue_command(mk(srsw_pkg::ACT_SEND, 0, 1'b0, 64'hFEDC_BA98_7654_3210));
        issue_command(mk(srsw_pkg::ACT_SEND, 0, 1'b0, 64'h8000_0000_0000_0001));
        issue_command(mk(srsw_pkg::ACT_SEND, 0, 1'b0, 64'h7FFF_FFFF_FFFF_FFFE));
        issue_command(mk(srsw_pkg::ACT_ACK, 3, 1'b1, '0));
        issue_command(mk(srsw_pkg::ACT_TIMEOUT, 6, 1'b0, '0));
        issue_command(mk(srsw_pkg::ACT_ACK, 6, 1'b1, '0));
        issue_command(mk(srsw_pkg::ACT_ACK, 5, 1'b1, '0));
        issue_command(mk(srsw_pkg::ACT_ACK, 4, 1'b1, '0));
        // sequence numbers wrap
        issue_command(mk(srsw_pkg::ACT_SEND, 0, 1'b1, 64'hDEAD_BEEF_0000_FFFF));
        issue_command(mk(srsw_pkg::ACT_SEND, 0, 1'b1, 64'h0000_FFFF_DEAD_BEEF));

        taken = 0;
        while (taken < RANDOM_ITEMS)
            issue_command(random_command());
        cmd.valid <= 1'b0;

        while (sb.expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d sends (%0d refused on a full window), %0d accepted acks,",
                 sb.n_send, sb.n_refused, sb.n_ack);
        $display("%0d base slides, %0d resends, %0d ignored events; %0d responses checked.",
                 sb.n_slide, sb.n_timeout, sb.n_ignored, sb.checked);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d responses still expected", sb.expected_rsp.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/srsw_pkg.sv
rtl/core/srsw_cmd_if.sv
rtl/core/srsw_rsp_if.sv
rtl/core/srsw_ram.sv
rtl/core/selective_repeat_sender_window.sv
rtl/core/srsw_checker.sv
sim/selective_repeat_sender_window_tb.sv
